// ===== rtl/core/fixed_point_vertex_transform_macros.svh =====
// Assertion macros shared by the vertex transform RTL.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef FIXED_POINT_VERTEX_TRANSFORM_MACROS_SVH
`define FIXED_POINT_VERTEX_TRANSFORM_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPVT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fpvt_pkg.sv =====
// Types and constants of the fixed-point vertex transform.
// No dependencies; used by fpvt_row and fixed_point_vertex_transform.
`timescale 1ns / 1ps

package fpvt_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int COEF_WIDTH  = 16;
  localparam int FRAC_BITS   = 12;
  localparam int ACC_WIDTH   = 2 * COORD_WIDTH;
  localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int ROW_WIDTH   = 4 * COEF_WIDTH;
  localparam int NUM_ROWS    = 3;
  localparam int CFG_IDX_WIDTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0 = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1 = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2 = 2'd2;

  // Reset matrix: identity in 4.12, zero translation
  localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 64'h0000_1000_0000_0000;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
    logic                          last_vertex;
  } fpvt_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          out_last;
  } fpvt_out_t;

  // Stage load enables from the pipeline control to each row unit
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } fpvt_ctrl_t;

endpackage

// ===== rtl/core/fixed_point_vertex_transform.sv =====
// Top level of the fixed-point affine vertex transform.
// Depends on fpvt_pkg, fpvt_row and fixed_point_vertex_transform_macros.svh.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid/in_ready/in_item) takes one vertex x, y, z plus a
//   last-vertex flag. Output channel (out_valid/out_ready/out_item) returns the
//   transformed vertex with the flag copied through.
//   Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) loads one
//   packed matrix row per write: three 4.12 coefficients and a translation.
//   cfg_ready is always high; writes to an index above the last row are
//   dropped. Write the matrix only while no item is in flight.
// Timing
//   Three register stages (products, sum, shift plus translate). An item
//   accepted on the input passes through them in order and is presented
//   on out_valid from the last. One item per cycle is sustained while
//   out_ready stays high.
// Reset
//   rst (synchronous) empties the pipeline and loads the identity matrix
//   with zero translation.
// Stall
//   When out_ready is low the final stage holds its item and bubbles behind
//   it collapse; in_ready drops only when all three stages hold items.
`include "fixed_point_vertex_transform_macros.svh"

module fixed_point_vertex_transform (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  fpvt_pkg::fpvt_in_t                    in_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output fpvt_pkg::fpvt_out_t                   out_item,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fpvt_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [fpvt_pkg::ROW_WIDTH-1:0]        cfg_data
);
  import fpvt_pkg::*;

  // Matrix rows, each read at its own fixed row unit
  logic [ROW_WIDTH-1:0] mat_rows [NUM_ROWS];

  // Valid bits and the last flag travel with the data
  logic       v1, v2, v3;
  logic       last1, last2, last3;
  logic       rdy1, rdy2, rdy3;
  fpvt_ctrl_t ctrl;
  logic signed [COORD_WIDTH-1:0] coords [NUM_ROWS];

  // Ready ripples back: a stage may load when empty or when it moves on
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign ctrl.ld1 = in_valid && rdy1;
  assign ctrl.ld2 = v1 && rdy2;
  assign ctrl.ld3 = v2 && rdy3;

  assign cfg_ready = 1'b1;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mat_rows[0] <= ROW0_RESET;
      mat_rows[1] <= ROW1_RESET;
      mat_rows[2] <= ROW2_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW0: mat_rows[0] <= cfg_data;
        REG_ROW1: mat_rows[1] <= cfg_data;
        REG_ROW2: mat_rows[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits: advance when the stage loads, clear when it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // Last flag rides alongside the coordinates
  always_ff @(posedge clk) begin
    if (ctrl.ld1) last1 <= in_item.last_vertex;
    if (ctrl.ld2) last2 <= last1;
    if (ctrl.ld3) last3 <= last2;
  end

  // One row unit per output coordinate
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    fpvt_row u_row (
      .clk   (clk),
      .ctrl  (ctrl),
      .row   (mat_rows[r]),
      .x     (in_item.in_x),
      .y     (in_item.in_y),
      .z     (in_item.in_z),
      .coord (coords[r])
    );
  end

  assign out_valid         = v3;
  assign out_item.out_x    = coords[0];
  assign out_item.out_y    = coords[1];
  assign out_item.out_z    = coords[2];
  assign out_item.out_last = last3;

  // Input only stalls when every stage is full and the output is blocked
  `FPVT_ASSERT_SAME(a_stall_full, !in_ready, v1 && v2 && v3 && !out_ready, "stall with room left")
  // An accepted item occupies stage one in the next cycle
  `FPVT_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1, "accepted item lost at stage one")
  // A blocked output keeps the stage behind it occupied
  `FPVT_ASSERT_NEXT(a_hold_stage2, v2 && v3 && !out_ready, v2 && v3, "item dropped during stall")
  // A full stage two moves into the output when the output drains
  `FPVT_ASSERT_NEXT(a_drain_move, v2 && out_ready, out_valid, "stage two item did not advance")

endmodule

// ===== rtl/core/fpvt_row.sv =====
// One output row of the vertex transform: products, sum, shift and translate.
// Depends on fpvt_pkg; stage enables come from the top-level pipeline control.
`timescale 1ns / 1ps

module fpvt_row (
  input  logic                                   clk,
  input  fpvt_pkg::fpvt_ctrl_t                   ctrl,
  input  logic [fpvt_pkg::ROW_WIDTH-1:0]         row,
  input  logic signed [fpvt_pkg::COORD_WIDTH-1:0] x,
  input  logic signed [fpvt_pkg::COORD_WIDTH-1:0] y,
  input  logic signed [fpvt_pkg::COORD_WIDTH-1:0] z,
  output logic signed [fpvt_pkg::COORD_WIDTH-1:0] coord
);
  import fpvt_pkg::*;

  logic signed [COEF_WIDTH-1:0]  m0, m1, m2, trans;
  logic signed [COORD_WIDTH-1:0] trans_ext;
  logic signed [PROD_WIDTH-1:0]  prod0, prod1, prod2;
  logic signed [ACC_WIDTH-1:0]   acc;
  logic signed [ACC_WIDTH-1:0]   acc_next;

  assign m0    = signed'(row[0*COEF_WIDTH +: COEF_WIDTH]);
  assign m1    = signed'(row[1*COEF_WIDTH +: COEF_WIDTH]);
  assign m2    = signed'(row[2*COEF_WIDTH +: COEF_WIDTH]);
  assign trans = signed'(row[3*COEF_WIDTH +: COEF_WIDTH]);
  assign trans_ext = COORD_WIDTH'(trans);

  // Sum wraps at the accumulator width
  assign acc_next = ACC_WIDTH'(prod0) + ACC_WIDTH'(prod1) + ACC_WIDTH'(prod2);

  // Stage 1: three products
  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      prod0 <= m0 * x;
      prod1 <= m1 * y;
      prod2 <= m2 * z;
    end
  end

  // Stage 2: wrapped sum
  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      acc <= acc_next;
    end
  end

  // Stage 3: drop fraction bits, truncate, add translation
  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      coord <= signed'(acc[FRAC_BITS +: COORD_WIDTH]) + trans_ext;
    end
  end

endmodule
